>>> rtl/core/sma_pkg.sv
package sma_pkg;

    localparam int unsigned PosWidth = 32;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_MOVE_ABS = 3'd1,
        REQ_MOVE_REL = 3'd2,
        REQ_LOAD_POS = 3'd3,
        REQ_SET_VEL  = 3'd4,
        REQ_GO       = 3'd5,
        REQ_STOP     = 3'd6
    } req_type_t;

    typedef enum logic {
        CFG_LOW_LIMIT  = 1'b0,
        CFG_HIGH_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        req_type_t                    req_type;
        logic signed [PosWidth-1:0]   value;
    } sma_req_t;

    typedef struct packed {
        logic signed [PosWidth-1:0]   position;
        logic                         at_high_limit;
        logic                         at_low_limit;
        logic                         in_motion;
    } sma_rsp_t;

    typedef struct packed {
        logic signed [PosWidth-1:0]   position;
        logic signed [PosWidth-1:0]   velocity;
        logic signed [PosWidth-1:0]   distance;
        logic                         moving;
        logic                         high_flag;
        logic                         low_flag;
    } axis_state_t;

    localparam logic signed [PosWidth-1:0] PosMax = {1'b0, {(PosWidth-1){1'b1}}};
    localparam logic signed [PosWidth-1:0] PosMin = {1'b1, {(PosWidth-1){1'b0}}};

    function automatic logic signed [PosWidth-1:0] sat_pos(input logic signed [PosWidth:0] v);
        logic signed [PosWidth-1:0] r;
        if (v[PosWidth] != v[PosWidth-1]) begin
            r = v[PosWidth] ? PosMin : PosMax;
        end else begin
            r = v[PosWidth-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/sma_step.sv
module sma_step
    import sma_pkg::*;
(
    input  axis_state_t                 state,
    input  sma_req_t                    req,
    input  logic signed [PosWidth-1:0]  low_limit,
    input  logic signed [PosWidth-1:0]  high_limit,
    output axis_state_t                 state_next
);

    logic signed [PosWidth:0] pos_w;
    logic signed [PosWidth:0] vel_w;
    logic signed [PosWidth:0] dist_w;
    logic signed [PosWidth:0] val_w;
    logic signed [PosWidth:0] vel_mag;
    logic signed [PosWidth:0] dist_mag;
    logic signed [PosWidth:0] step_w;
    logic signed [PosWidth:0] sum_w;
    logic signed [PosWidth:0] hclamp_w;
    logic signed [PosWidth:0] lclamp_w;
    logic                     clip;
    logic                     hit_high;
    logic                     hit_low;

    assign pos_w    = {state.position[PosWidth-1], state.position};
    assign vel_w    = {state.velocity[PosWidth-1], state.velocity};
    assign dist_w   = {state.distance[PosWidth-1], state.distance};
    assign val_w    = {req.value[PosWidth-1], req.value};
    assign vel_mag  = vel_w[PosWidth] ? -vel_w : vel_w;
    assign dist_mag = dist_w[PosWidth] ? -dist_w : dist_w;

    // tick: last step clipped to the remaining distance
    assign clip     = vel_mag >= dist_mag;
    assign step_w   = clip ? dist_w : vel_w;
    assign sum_w    = pos_w + step_w;
    assign hit_high = sum_w >= $signed({high_limit[PosWidth-1], high_limit});
    assign hclamp_w = hit_high ? {high_limit[PosWidth-1], high_limit} : sum_w;
    assign hit_low  = hclamp_w <= $signed({low_limit[PosWidth-1], low_limit});
    assign lclamp_w = hit_low ? {low_limit[PosWidth-1], low_limit} : hclamp_w;

    always_comb begin
        state_next = state;
        case (req.req_type)
            REQ_TICK: begin
                if (state.moving) begin
                    state_next.position  = lclamp_w[PosWidth-1:0];
                    state_next.high_flag = hit_high;
                    state_next.low_flag  = hit_low;
                    state_next.distance  = sat_pos(dist_w - step_w);
                    state_next.moving    = !clip;
                end
            end
            REQ_MOVE_ABS: state_next.distance = sat_pos(val_w - pos_w);
            REQ_MOVE_REL: state_next.distance = req.value;
            REQ_LOAD_POS: state_next.position = req.value;
            REQ_SET_VEL:  state_next.velocity = req.value;
            REQ_GO: begin
                if (state.distance != '0 && state.velocity != '0) begin
                    state_next.velocity = sat_pos(dist_w[PosWidth] ? -vel_mag : vel_mag);
                    state_next.moving   = 1'b1;
                end
            end
            REQ_STOP: begin
                if (state.moving) begin
                    state_next.moving   = 1'b0;
                    state_next.distance = '0;
                end
            end
            default: state_next = state;
        endcase
    end

endmodule

>>> rtl/core/simulated_motor_axis.sv
// channel   direction  ports                                   payload
// command   in         s_valid, s_ready, s_req                 sma_req_t
// status    out        m_valid, m_ready, m_rsp                 sma_rsp_t
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data  limit registers
//
// one command per cycle while s_ready is high; the status for a command is on m_rsp in the cycle after its transfer
// a tick's position update is a 33-bit add, three compares (clip, high, low) and two clamps
// s_ready is low only while a status waits and m_ready is low
// aresetn (synchronous) clears the axis state and sets the limits to the full range
module simulated_motor_axis
    import sma_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sma_req_t                    s_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output sma_rsp_t                    m_rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  cfg_index_t                  cfg_index,
    input  logic signed [PosWidth-1:0]  cfg_data
);

    axis_state_t                 state_reg;
    axis_state_t                 state_next;
    sma_rsp_t                    rsp_reg;
    logic                        m_valid_reg;
    logic signed [PosWidth-1:0]  low_limit_reg;
    logic signed [PosWidth-1:0]  high_limit_reg;
    logic                        s_xfer;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_rsp     = rsp_reg;

    sma_step u_step (
        .state      (state_reg),
        .req        (s_req),
        .low_limit  (low_limit_reg),
        .high_limit (high_limit_reg),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '0;
            m_valid_reg    <= 1'b0;
            low_limit_reg  <= PosMin;
            high_limit_reg <= PosMax;
        end else begin
            if (s_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                    CFG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // status payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            rsp_reg.position      <= state_next.position;
            rsp_reg.at_high_limit <= state_next.high_flag;
            rsp_reg.at_low_limit  <= state_next.low_flag;
            rsp_reg.in_motion     <= state_next.moving;
        end
    end

    a_xfer_gives_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid)
        else $error("transfer did not produce a status");

    a_status_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.position == state_reg.position
                     && m_rsp.in_motion == state_reg.moving))
        else $error("status out of step with axis state");

    a_high_flag_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.high_flag) |-> $past(s_xfer && s_req.req_type == REQ_TICK))
        else $error("high limit flag set outside a tick");

    a_go_needs_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.moving) |-> $past(state_reg.distance) != '0)
        else $error("motion started with no distance left");

endmodule
